### design/ir_pulse_length_frame_encoder_top_defines.svh
// Assertion macros used by the top level of the pulse-length frame encoder.
`ifndef IR_PULSE_LENGTH_FRAME_ENCODER_TOP_DEFINES_SVH
`define IR_PULSE_LENGTH_FRAME_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk and held off during rst.
`define IRPLFE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("irplfe same-cycle check failed");

// Next-cycle implication, checked on clk and held off during rst.
`define IRPLFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("irplfe next-cycle check failed");

`endif

### design/irplfe_pkg.sv
// Types and constants of the pulse-length frame encoder.
`default_nettype none
package irplfe_pkg;

  typedef struct packed {
    logic [2:0] cmd;
    logic [8:0] payload;
  } in_item_t;

  typedef struct packed {
    logic       is_mark;
    logic [4:0] duration_ms;
    logic       last;
  } out_item_t;

  // Classified request as it travels from the front to the back.
  typedef struct packed {
    logic       has_header;
    logic       long_mark2;
    logic       tag_gap;
    logic [3:0] top_bit;
    logic [8:0] value;
  } frame_desc_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

  localparam logic [2:0] CMD_PACKET   = 3'd0;
  localparam logic [2:0] CMD_DATA     = 3'd1;
  localparam logic [2:0] CMD_CHECKSUM = 3'd2;
  localparam logic [2:0] CMD_TAG      = 3'd3;
  localparam logic [2:0] CMD_BEACON   = 3'd4;
  localparam logic [2:0] CMD_LBEACON  = 3'd5;

  localparam logic [3:0] TOP_BIT_9 = 4'd8;
  localparam logic [3:0] TOP_BIT_8 = 4'd7;
  localparam logic [3:0] TOP_BIT_7 = 4'd6;
  localparam logic [3:0] TOP_BIT_5 = 4'd4;

  localparam logic [4:0] MS_HDR_MARK   = 5'd3;
  localparam logic [4:0] MS_HDR_SPACE  = 5'd6;
  localparam logic [4:0] MS_MARK2_LONG = 5'd6;
  localparam logic [4:0] MS_BIT_SPACE  = 5'd2;
  localparam logic [4:0] MS_BIT_MARK0  = 5'd1;
  localparam logic [4:0] MS_GAP_LONG   = 5'd25;
  localparam logic [4:0] MS_GAP_TAG    = 5'd5;

endpackage
`default_nettype wire

### design/ir_pulse_length_frame_encoder_top.sv
// Top level of the infrared pulse-length frame encoder.
`default_nettype none
// Usage:
//   Input channel in_valid / in_ready / in_data carries one message request
//   (type and 9-bit value). Output channel out_valid / out_ready / out_data
//   carries one mark or space segment per request moved.
//   A message becomes 3 header segments, two segments per sent bit and one
//   trailing gap flagged by last: 4 + 2 * bits segments, 22 at most, or a
//   single gap for an unused type.
//   With the block idle, an accepted message goes into the queue, then into
//   the sequencer state, and its first segment then into the output register.
//   Throughput: one segment per cycle from the back sequencer while the
//   receiver does not stall; the next message in the queue follows the
//   trailing gap without a bubble.
//   The front keeps accepting messages while the queue (QUEUE_DEPTH
//   entries, a power of two) has room, so a stalled receiver holds only
//   the output register and the sequencer; the front stalls once the
//   queue fills.
//   Reset (rst, synchronous) clears the running checksum to zero, empties
//   the queue and drops any partly sent frame.
module ir_pulse_length_frame_encoder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire irplfe_pkg::in_item_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output irplfe_pkg::out_item_t      out_data
);
  import irplfe_pkg::*;
  `include "ir_pulse_length_frame_encoder_top_defines.svh"

  frame_desc_t push_desc;
  frame_desc_t head_desc;
  q_status_t   q_status;
  logic        push;
  logic        pop;
  logic        mark_len_ok;

  // Classify each request and update the checksum at acceptance.
  irplfe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_status (q_status),
    .push     (push),
    .desc     (push_desc)
  );

  // Hold classified requests until the sequencer is free.
  irplfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head_desc (head_desc),
    .status    (q_status)
  );

  // Advance through the segments of each frame, one per cycle while the receiver does not stall.
  irplfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .head_desc (head_desc),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign mark_len_ok = (out_data.duration_ms <= MS_MARK2_LONG) &&
                       (out_data.duration_ms != 5'd0);

  // The trailing gap is always a space.
  `IRPLFE_ASSERT_NOW(a_gap_is_space, out_valid && out_data.last, !out_data.is_mark)
  // Marks never exceed the long header mark.
  `IRPLFE_ASSERT_NOW(a_mark_len, out_valid && out_data.is_mark, mark_len_ok)
  // A push into a queue with no waiting entry makes it non-empty next cycle.
  `IRPLFE_ASSERT_NEXT(a_push_lands, push && !q_status.not_empty, q_status.not_empty || pop)

endmodule
`default_nettype wire

### design/irplfe_front.sv
// Front: accepts requests, classifies them and keeps the running checksum.
`default_nettype none
module irplfe_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire irplfe_pkg::in_item_t   in_data,
  input  wire irplfe_pkg::q_status_t  q_status,
  output logic                        push,
  output irplfe_pkg::frame_desc_t     desc
);
  import irplfe_pkg::*;

  logic [7:0] running_sum;
  logic [7:0] running_sum_next;

  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    desc.has_header  = 1'b1;
    desc.long_mark2  = 1'b0;
    desc.tag_gap     = 1'b0;
    desc.top_bit     = TOP_BIT_9;
    desc.value       = in_data.payload;
    running_sum_next = running_sum;
    case (in_data.cmd)
      CMD_PACKET: begin
        running_sum_next = in_data.payload[7:0];
      end
      CMD_DATA: begin
        desc.top_bit     = TOP_BIT_8;
        running_sum_next = running_sum + in_data.payload[7:0];
      end
      CMD_CHECKSUM: begin
        desc.value = {1'b1, running_sum};
      end
      CMD_TAG: begin
        desc.top_bit = TOP_BIT_7;
        desc.tag_gap = 1'b1;
      end
      CMD_BEACON: begin
        desc.top_bit    = TOP_BIT_5;
        desc.long_mark2 = 1'b1;
      end
      CMD_LBEACON: begin
        desc.long_mark2 = 1'b1;
      end
      default: begin
        // unused type: gap only
        desc.has_header = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= 8'd0;
    end else if (push) begin
      running_sum <= running_sum_next;
    end
  end

endmodule
`default_nettype wire

### design/irplfe_queue.sv
// Short descriptor queue between the front and the back.
`default_nettype none
module irplfe_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  input  wire irplfe_pkg::frame_desc_t  push_desc,
  input  wire logic                     pop,
  output irplfe_pkg::frame_desc_t       head_desc,
  output irplfe_pkg::q_status_t         status
);
  import irplfe_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  frame_desc_t entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign status.not_empty = (count != '0);
  assign status.full      = (count == CntW'(DEPTH));
  assign do_push          = push && !status.full;
  assign do_pop           = pop && status.not_empty;
  assign head_desc        = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### design/irplfe_back.sv
// Back: segment sequencer and registered output stage.
`default_nettype none
module irplfe_back (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire irplfe_pkg::q_status_t    q_status,
  input  wire irplfe_pkg::frame_desc_t  head_desc,
  output logic                          pop,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output irplfe_pkg::out_item_t         out_data
);
  import irplfe_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_HDR0 = 7'b0000010,
    S_HDR1 = 7'b0000100,
    S_HDR2 = 7'b0001000,
    S_BSP  = 7'b0010000,
    S_BMK  = 7'b0100000,
    S_GAP  = 7'b1000000
  } seq_state_t;

  seq_state_t  state;
  seq_state_t  state_next;
  frame_desc_t cur;
  logic [3:0]  bit_idx;
  logic [3:0]  bit_idx_next;
  out_item_t   seg;
  logic        emit;
  logic        load;

  assign emit = (state != S_IDLE) && (!out_valid || out_ready);
  assign load = q_status.not_empty && ((state == S_IDLE) || (emit && state == S_GAP));
  assign pop  = load;

  always_comb begin
    seg.is_mark     = 1'b0;
    seg.duration_ms = MS_GAP_LONG;
    seg.last        = 1'b0;
    case (state)
      S_HDR0: begin
        seg.is_mark     = 1'b1;
        seg.duration_ms = MS_HDR_MARK;
      end
      S_HDR1: begin
        seg.duration_ms = MS_HDR_SPACE;
      end
      S_HDR2: begin
        seg.is_mark     = 1'b1;
        seg.duration_ms = cur.long_mark2 ? MS_MARK2_LONG : MS_HDR_MARK;
      end
      S_BSP: begin
        seg.duration_ms = MS_BIT_SPACE;
      end
      S_BMK: begin
        seg.is_mark     = 1'b1;
        seg.duration_ms = MS_BIT_MARK0 + {4'd0, cur.value[bit_idx]};
      end
      S_GAP: begin
        seg.duration_ms = cur.tag_gap ? MS_GAP_TAG : MS_GAP_LONG;
        seg.last        = 1'b1;
      end
      default: begin
        seg.duration_ms = MS_GAP_LONG;
      end
    endcase
  end

  always_comb begin
    state_next   = state;
    bit_idx_next = bit_idx;
    if (emit) begin
      case (state)
        S_HDR0:  state_next = S_HDR1;
        S_HDR1:  state_next = S_HDR2;
        S_HDR2:  state_next = S_BSP;
        S_BSP:   state_next = S_BMK;
        S_BMK: begin
          if (bit_idx == 4'd0) begin
            state_next = S_GAP;
          end else begin
            state_next   = S_BSP;
            bit_idx_next = bit_idx - 4'd1;
          end
        end
        S_GAP:   state_next = S_IDLE;
        default: state_next = S_IDLE;
      endcase
    end
    if (load) begin
      state_next   = head_desc.has_header ? S_HDR0 : S_GAP;
      bit_idx_next = head_desc.top_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    bit_idx <= bit_idx_next;
    if (load) begin
      cur <= head_desc;
    end
    if (emit) begin
      out_data <= seg;
    end
  end

endmodule
`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for the infrared pulse-length frame encoder.
`timescale 1ns / 100ps

module tb_top;
  import irplfe_pkg::*;

  // Type codes the block does not define: each yields only a trailing gap.
  localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7 = 3'd7;
  // Mark length for a one bit; a zero bit uses MS_BIT_MARK0 from the package.
  localparam logic [4:0] MS_BIT_MARK1 = 5'd2;

  localparam int unsigned RESET_CYCLES   = 5;
  // Idle time after the last expected segment.
  localparam int unsigned SETTLE_CYCLES  = 30;
  // Long receiver hold-off, enough to fill the queue and stall the input.
  localparam int unsigned RX_HOLD_CYCLES = 400;
  // Hard stop: many times the slowest legal run (every segment meeting the longest stall).
  localparam longint unsigned WATCHDOG_NS = 64'd20_000_000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Segments still owed by the block, oldest first.
  out_item_t   frame_segments[$];
  // Running checksum as the block should hold it after every accepted request.
  logic [7:0]  checksum_acc = '0;
  int unsigned mismatch_count = 0;

  // Idling controls: tx side gaps between requests, rx side stalls on out_ready.
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int unsigned rx_hold_req = 0;
  int unsigned rx_stall_left = 0;

  ir_pulse_length_frame_encoder_top dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Gap length in cycles: mostly short, now and then long.
  function automatic int unsigned gap_cycles();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      return $urandom_range(1, 3);
    end else if (pick < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic out_item_t seg(input logic mark, input logic [4:0] ms, input logic ends);
    out_item_t s;
    s.is_mark     = mark;
    s.duration_ms = ms;
    s.last        = ends;
    return s;
  endfunction

  // Work out the frame for one accepted request and queue its segments.
  // Update the running checksum exactly as the block does.
  task automatic encode_frame(input in_item_t req);
    logic [8:0] bits_val;
    int         nbits;
    logic [4:0] mark2_ms;
    logic [4:0] gap_ms;
    logic       send_header;
    bits_val    = req.payload;
    nbits       = 0;
    mark2_ms    = MS_HDR_MARK;
    gap_ms      = MS_GAP_LONG;
    send_header = 1'b1;
    case (req.cmd)
      CMD_PACKET: begin
        nbits        = 9;
        checksum_acc = req.payload[7:0];
      end
      CMD_DATA: begin
        nbits        = 8;
        checksum_acc = checksum_acc + req.payload[7:0];
      end
      CMD_CHECKSUM: begin
        // payload is ignored; send the sum with the flag bit on top
        nbits    = 9;
        bits_val = {1'b1, checksum_acc};
      end
      CMD_TAG: begin
        nbits  = 7;
        gap_ms = MS_GAP_TAG;
      end
      CMD_BEACON: begin
        nbits    = 5;
        mark2_ms = MS_MARK2_LONG;
      end
      CMD_LBEACON: begin
        nbits    = 9;
        mark2_ms = MS_MARK2_LONG;
      end
      default: begin
        send_header = 1'b0;
      end
    endcase
    if (send_header) begin
      frame_segments.push_back(seg(1'b1, MS_HDR_MARK, 1'b0));
      frame_segments.push_back(seg(1'b0, MS_HDR_SPACE, 1'b0));
      frame_segments.push_back(seg(1'b1, mark2_ms, 1'b0));
    end
    for (int i = nbits - 1; i >= 0; i--) begin
      frame_segments.push_back(seg(1'b0, MS_BIT_SPACE, 1'b0));
      frame_segments.push_back(seg(1'b1, bits_val[i] ? MS_BIT_MARK1 : MS_BIT_MARK0, 1'b0));
    end
    frame_segments.push_back(seg(1'b0, gap_ms, 1'b1));
  endtask

  // Offer one request and hold it until the block takes it.
  // Call at a rising edge; valid is left high so a following request
  // can go out on the very next cycle.
  task automatic send_request(input in_item_t req);
    int unsigned gap;
    if (tx_idle_en && $urandom_range(0, 99) < 30) begin
      gap = gap_cycles();
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    encode_frame(req);
  endtask

  task automatic send_cmd(input logic [2:0] cmd, input logic [8:0] payload);
    in_item_t req;
    req.cmd     = cmd;
    req.payload = payload;
    send_request(req);
  endtask

  function automatic in_item_t random_request();
    in_item_t req;
    // a tenth of the traffic uses the undefined type codes
    if ($urandom_range(0, 99) < 10) begin
      req.cmd = 3'($urandom_range(CMD_UNUSED_6, CMD_UNUSED_7));
    end else begin
      req.cmd = 3'($urandom_range(CMD_PACKET, CMD_LBEACON));
    end
    req.payload = 9'($urandom_range(0, 511));
    return req;
  endfunction

  // Stop offering, then wait for every owed segment and a quiet spell.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_segments.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Field extremes, every type, checksum wrap-round and the unused type codes.
  task automatic test_directed_cases();
    send_cmd(CMD_CHECKSUM, 9'd0);       // sum straight out of reset
    send_cmd(CMD_PACKET, 9'd0);
    send_cmd(CMD_PACKET, 9'd511);       // packet top bit goes out as given
    send_cmd(CMD_CHECKSUM, 9'd0);
    send_cmd(CMD_PACKET, 9'h0F0);
    send_cmd(CMD_DATA, 9'h020);         // sum wraps past 255
    send_cmd(CMD_DATA, 9'h1FF);         // data bit 8 plays no part in the sum
    send_cmd(CMD_CHECKSUM, 9'd511);     // payload ignored
    send_cmd(CMD_DATA, 9'd0);
    send_cmd(CMD_DATA, 9'd255);
    send_cmd(CMD_CHECKSUM, 9'h0AA);
    send_cmd(CMD_TAG, 9'd0);
    send_cmd(CMD_TAG, 9'd127);
    send_cmd(CMD_TAG, 9'h180);          // bits above the seventh are not sent
    send_cmd(CMD_BEACON, 9'h01F);
    send_cmd(CMD_BEACON, 9'h1E0);
    send_cmd(CMD_LBEACON, 9'h1FF);
    send_cmd(CMD_LBEACON, 9'h155);
    send_cmd(CMD_UNUSED_6, 9'h1FF);     // gap only, sum untouched
    send_cmd(CMD_UNUSED_7, 9'd0);
    send_cmd(CMD_CHECKSUM, 9'd0);
    wait_for_drain();
  endtask

  // Full rate on both sides: frames should follow one another with no bubble.
  task automatic test_back_to_back();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (15) send_request(random_request());
    wait_for_drain();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Hold the receiver off for a long stretch while requests keep coming,
  // so the queue fills and the input stalls.
  task automatic test_receiver_hold_off();
    tx_idle_en  = 1'b0;
    rx_hold_req = RX_HOLD_CYCLES;
    repeat (10) send_request(random_request());
    wait_for_drain();
    tx_idle_en = 1'b1;
  endtask

  // Pause the sender until the block has emptied, then carry on.
  task automatic test_sender_pause();
    repeat (3) begin
      send_cmd(CMD_PACKET, 9'($urandom_range(0, 511)));
      send_cmd(CMD_CHECKSUM, 9'($urandom_range(0, 511)));
      wait_for_drain();
    end
  endtask

  // Mostly well-formed checksum runs with random content, the rest single
  // requests of any type, broken runs and undefined codes among them.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned n_data;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 60) begin
        n_data = $urandom_range(0, 4);
        send_cmd(CMD_PACKET, 9'($urandom_range(0, 511)));
        repeat (n_data) send_cmd(CMD_DATA, 9'($urandom_range(0, 511)));
        send_cmd(CMD_CHECKSUM, 9'($urandom_range(0, 511)));
        sent += n_data + 2;
      end else begin
        send_request(random_request());
        sent++;
      end
    end
    wait_for_drain();
  endtask

  // Receiver: drop ready for random stalls, or for a long hold-off when one
  // is requested; keep the count here so the sender runs on undisturbed.
  always @(posedge clk) begin
    if (rx_hold_req != 0) begin
      rx_stall_left = rx_hold_req;
      rx_hold_req   = 0;
    end
    if (rst || rx_stall_left != 0) begin
      out_ready <= 1'b0;
      if (rx_stall_left != 0) begin
        rx_stall_left--;
      end
    end else begin
      out_ready <= 1'b1;
      if (rx_idle_en && $urandom_range(0, 99) < 20) begin
        rx_stall_left = gap_cycles();
      end
    end
  end

  // Compare every segment the receiver takes with the oldest one owed.
  always @(posedge clk) begin : check_segment
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (frame_segments.size() == 0) begin
        $error("segment with no request pending: is_mark %0d duration_ms %0d last %0d",
               out_data.is_mark, out_data.duration_ms, out_data.last);
        mismatch_count++;
      end else begin
        want = frame_segments.pop_front();
        if (out_data.is_mark !== want.is_mark) begin
          $error("is_mark: expected %0d, actual %0d", want.is_mark, out_data.is_mark);
          mismatch_count++;
        end
        if (out_data.duration_ms !== want.duration_ms) begin
          $error("duration_ms: expected %0d, actual %0d",
                 want.duration_ms, out_data.duration_ms);
          mismatch_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_data.last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_back_to_back();
    test_receiver_hold_off();
    test_sender_pause();
    test_random_traffic(120);
    // anything still owed at this point is a failure too
    if (mismatch_count == 0 && frame_segments.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: end a hung run.
  initial begin
    #(WATCHDOG_NS);
    $display("FAILURE");
    $finish;
  end

endmodule
